/* rtl/dgsd_pkg.sv */
`timescale 1ns / 1ps

package dgsd_pkg;

    // Default axis width and fixed field widths
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TIME_W           = 32;
    localparam int COUNT_W          = 32;
    localparam int FILT_W           = 24;
    localparam int THR_W            = 16;
    localparam int ALPHA_W          = 9;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [FILT_W-1:0] FILT_MAX = {FILT_W{1'b1}};

    // Register reset values
    localparam logic [THR_W-1:0]   ACCEL_THR_RST = 16'd2944;
    localparam logic [THR_W-1:0]   GYRO_THR_RST  = 16'd1024;
    localparam logic [THR_W-1:0]   MIN_INT_RST   = 16'd250;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd77;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;

    // Item kinds on tuser
    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DIFF,
        ST_MUL,
        ST_FILT,
        ST_DECIDE,
        ST_CLEAR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear;
        logic square;
        logic root;
        logic diff;
        logic mul;
        logic filt;
        logic decide;
        logic post;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/dgsd_ctrl.sv */
`timescale 1ns / 1ps

module dgsd_ctrl import dgsd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_action,
    output logic    o_s_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam int CNT_W = $clog2(SAMPLE_WIDTH);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = (i_action == ACT_CLEAR) ? ST_CLEAR : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                o_cmd.root = 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DIFF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FILT;
            end
            ST_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_OUT;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dgsd_datapath.sv */
`timescale 1ns / 1ps

module dgsd_datapath import dgsd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_dp_cmd                                  i_cmd,
    output t_dp_sts                                  o_sts,
    input  logic [((6*SAMPLE_WIDTH+TIME_W+7)/8)*8-1:0] i_s_data,
    input  logic                                     i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]                     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                    i_cfg_data,
    input  logic                                     i_m_ready,
    output logic                                     o_m_valid,
    output logic [COUNT_W-1:0]                       o_m_count,
    output logic                                     o_m_det
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = 2 * SW;
    localparam int REM_W = SW + 3;
    localparam int D_W   = SW + 18;
    localparam int P_W   = D_W + ALPHA_W + 1;
    localparam int Q_W   = P_W - 8;
    localparam int NF_W  = Q_W + 1;

    // configuration registers
    logic [THR_W-1:0]   r_athr, r_gthr, r_mint;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ALPHA_W-1:0] alpha_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_athr  <= ACCEL_THR_RST;
            r_gthr  <= GYRO_THR_RST;
            r_mint  <= MIN_INT_RST;
            r_alpha <= ALPHA_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACCEL_THR: r_athr  <= i_cfg_data;
                CFG_GYRO_THR:  r_gthr  <= i_cfg_data;
                CFG_MIN_INT:   r_mint  <= i_cfg_data;
                CFG_ALPHA:     r_alpha <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // alpha of zero behaves as one, above unity saturates at unity (256)
    always_comb begin
        if (r_alpha == '0) begin
            alpha_eff = ALPHA_W'(1);
        end else if (r_alpha > ALPHA_W'(256)) begin
            alpha_eff = ALPHA_W'(256);
        end else begin
            alpha_eff = r_alpha;
        end
    end

    logic [TIME_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_s_data[6*SW +: TIME_W];
        end
    end

    // two lanes: lane 0 accel, lane 1 gyro
    logic [FILT_W-1:0] r_f [2];
    logic              f_gt [2];

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic signed [SW-1:0]    r_ax [3];
        logic [SUM_W-1:0]        r_sum;
        logic [REM_W-1:0]        r_rem;
        logic [SW-1:0]           r_root;
        logic signed [D_W-1:0]   r_d;
        logic signed [P_W-1:0]   r_p;
        logic signed [SUM_W-1:0] sq;
        logic [REM_W-1:0]        rem_sh, trial;
        logic signed [P_W-1:0]   biased;
        logic signed [Q_W-1:0]   q;
        logic signed [NF_W-1:0]  nf;
        logic [THR_W-1:0]        thr;

        assign sq     = r_ax[0] * r_ax[0];
        assign rem_sh = {r_rem[REM_W-3:0], r_sum[SUM_W-1 -: 2]};
        assign trial  = {{(REM_W-SW-2){1'b0}}, r_root, 2'b01};
        // truncate toward zero: bias negatives before the arithmetic shift
        assign biased = r_p + $signed({{(P_W-8){1'b0}}, {8{r_p[P_W-1]}}});
        assign q      = biased[P_W-1:8];
        assign nf     = $signed({{(NF_W-FILT_W){1'b0}}, r_f[g]}) + $signed({q[Q_W-1], q});
        assign thr    = (g == 0) ? r_athr : r_gthr;
        assign f_gt[g] = r_f[g] > {thr, 8'b0};

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                for (int k = 0; k < 3; k++) begin
                    r_ax[k] <= i_s_data[(3*g+k)*SW +: SW];
                end
                r_sum  <= '0;
                r_rem  <= '0;
                r_root <= '0;
            end else if (i_cmd.square) begin
                r_sum <= r_sum + $unsigned(sq);
                r_ax[0] <= r_ax[1];
                r_ax[1] <= r_ax[2];
                r_ax[2] <= r_ax[0];
            end else if (i_cmd.root) begin
                r_sum <= {r_sum[SUM_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[SW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[SW-2:0], 1'b0};
                end
            end
            if (i_cmd.diff) begin
                r_d <= $signed({10'b0, r_root, 8'b0})
                     - $signed({{(D_W-FILT_W){1'b0}}, r_f[g]});
            end
            if (i_cmd.mul) begin
                r_p <= $signed({1'b0, alpha_eff}) * r_d;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_f[g] <= '0;
            end else if (i_cmd.filt) begin
                if (nf < 0) begin
                    r_f[g] <= '0;
                end else if (nf > $signed({{(NF_W-FILT_W){1'b0}}, FILT_MAX})) begin
                    r_f[g] <= FILT_MAX;
                end else begin
                    r_f[g] <= nf[FILT_W-1:0];
                end
            end
        end
    end

    // step decision
    logic [COUNT_W-1:0] r_steps;
    logic [TIME_W-1:0]  r_last;
    logic               r_above, r_det;
    logic [TIME_W-1:0]  since;

    assign since = r_now - r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_steps <= '0;
            r_last  <= '0;
            r_above <= 1'b0;
            r_det   <= 1'b0;
        end else if (i_cmd.decide) begin
            r_det <= 1'b0;
            if (f_gt[0] && !r_above && f_gt[1]) begin
                r_above <= 1'b1;
                if (since >= {{(TIME_W-THR_W){1'b0}}, r_mint}) begin
                    r_steps <= r_steps + 1'b1;
                    r_last  <= r_now;
                    r_det   <= 1'b1;
                end
            end else if (!f_gt[0]) begin
                r_above <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (i_cmd.post) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            o_m_count <= r_steps;
            o_m_det   <= r_det;
        end
    end

    assign o_sts.out_free = !o_m_valid || i_m_ready;

endmodule

/* rtl/dual_gate_step_detector_unit.sv */
`timescale 1ns / 1ps

// Dual-gate step detector: counts steps from a stream of IMU samples.
//
// Input stream (s_axis): one sample per transaction. tuser is the action
// (0 process, 1 clear all detector state). tdata carries six signed axes
// of SAMPLE_WIDTH bits (accel x/y/z, gyro x/y/z) and a 32-bit ms timestamp.
// Output stream (m_axis): one result per input; tdata is the step count,
// tuser flags that this sample counted a new step.
// Config channel: index/data write, always ready; write only while idle.
//
// Processing: each axis of a sample is squared and accumulated, then the sum
// goes through the bit-serial square root (one root bit per cycle, both vectors
// in parallel), then through difference, alpha multiply, filter update and
// decision before the result is posted. A clear zeroes the detector state and
// then posts its result. One sample is in flight at a time: a new sample is
// accepted only once the previous result has been posted. The square-root
// iteration is the longest step.
// A result waits in the output register while m_axis_tready is low; the next
// sample is accepted meanwhile and its result holds back until the slot frees.
// Reset (synchronous, active low) restores register defaults and zeroes count,
// filters, edge flag and last-step time.

module dual_gate_step_detector_unit import dgsd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms, zero pad
    input  logic [((6*SAMPLE_WIDTH+TIME_W+7)/8)*8-1:0]  s_axis_tdata,
    // action
    input  logic                                        s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // step_count
    output logic [COUNT_W-1:0]                          m_axis_tdata,
    // step_detected
    output logic                                        m_axis_tuser,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                       i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config registers take a write every cycle
    assign o_cfg_ready = 1'b1;

    dgsd_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    dgsd_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_data    (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_count   (m_axis_tdata),
        .o_m_det     (m_axis_tuser)
    );

endmodule

/* rtl/dgsd_checker.sv */
`timescale 1ns / 1ps

module dgsd_checker import dgsd_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                                        i_clk,
    input logic                                        i_rst_n,
    input logic                                        s_axis_tvalid,
    input logic                                        s_axis_tready,
    input logic [((6*SAMPLE_WIDTH+TIME_W+7)/8)*8-1:0]  s_axis_tdata,
    input logic                                        s_axis_tuser,
    input logic                                        m_axis_tvalid,
    input logic                                        m_axis_tready,
    input logic [COUNT_W-1:0]                          m_axis_tdata,
    input logic                                        m_axis_tuser,
    input logic                                        i_cfg_valid,
    input logic                                        o_cfg_ready,
    input logic [CFG_IDX_W-1:0]                        i_cfg_index,
    input logic [CFG_DATA_W-1:0]                       i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one sample in flight: busy right after a transaction
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a sample is in flight");

    // a fresh result coincides with the input side opening again
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result posted while still busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_gate_step_detector_unit dgsd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dgsd_checker (.*);

/* test/dgsd_checker.sv */
`timescale 1ns / 1ps

module dgsd_tb_checker import dgsd_pkg::*; #(
    parameter int SW = SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [((6*SW+TIME_W+7)/8)*8-1:0]     i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [COUNT_W-1:0]                   i_m_tdata,
    input  logic                                 i_m_tuser,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending
);

    localparam int DATA_W = ((6*SW+TIME_W+7)/8)*8;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic               step_detected;
    } t_step_result;

    // Register shadow
    logic [THR_W-1:0]   accel_thr;
    logic [THR_W-1:0]   gyro_thr;
    logic [THR_W-1:0]   min_gap_ms;
    logic [ALPHA_W-1:0] alpha_reg;

    // Detector state
    logic [COUNT_W-1:0] step_total;
    logic [FILT_W-1:0]  accel_filt;
    logic [FILT_W-1:0]  gyro_filt;
    logic               edge_armed;
    logic [TIME_W-1:0]  last_step_ms;

    t_step_result expected_steps[$];

    function automatic longint axis_val(logic [SW-1:0] raw);
        logic signed [SW-1:0] s;
        s = raw;
        return longint'(s);
    endfunction

    // floor(sqrt(x^2 + y^2 + z^2)), one root bit at a time
    function automatic longint vec_len(longint x, longint y, longint z);
        longint sum;
        longint root;
        longint cand;
        sum  = x * x + y * y + z * z;
        root = 0;
        for (int bitpos = SW; bitpos >= 0; bitpos--) begin
            cand = root | (longint'(1) << bitpos);
            if (cand * cand <= sum)
                root = cand;
        end
        return root;
    endfunction

    // EMA at Q.8 scale; division truncates toward zero, result clamped
    function automatic logic [FILT_W-1:0] smooth(logic [FILT_W-1:0] f, longint mag, int a);
        longint fl;
        longint al;
        longint nf;
        fl = longint'(f);
        al = longint'(a);
        nf = fl + (al * ((mag << 8) - fl)) / 256;
        if (nf < 0)
            nf = 0;
        if (nf > longint'(FILT_MAX))
            nf = longint'(FILT_MAX);
        return nf[FILT_W-1:0];
    endfunction

    function automatic void clear_detector();
        step_total   = '0;
        accel_filt   = '0;
        gyro_filt    = '0;
        edge_armed   = 1'b0;
        last_step_ms = '0;
    endfunction

    function automatic t_step_result predict_step(logic act, logic [DATA_W-1:0] d);
        t_step_result      r;
        int                a;
        longint            amag;
        longint            gmag;
        logic [TIME_W-1:0] now;
        logic [31:0]       accel_lim;
        logic [31:0]       gyro_lim;
        r = '0;
        if (act == ACT_CLEAR) begin
            clear_detector();
            return r;
        end
        a = int'(alpha_reg);
        if (a == 0)
            a = 1;
        if (a > 256)
            a = 256;
        amag = vec_len(axis_val(d[0*SW +: SW]), axis_val(d[1*SW +: SW]),
                       axis_val(d[2*SW +: SW]));
        gmag = vec_len(axis_val(d[3*SW +: SW]), axis_val(d[4*SW +: SW]),
                       axis_val(d[5*SW +: SW]));
        now        = d[6*SW +: TIME_W];
        accel_filt = smooth(accel_filt, amag, a);
        gyro_filt  = smooth(gyro_filt, gmag, a);
        accel_lim  = {8'd0, accel_thr, 8'd0};
        gyro_lim   = {8'd0, gyro_thr, 8'd0};
        if (accel_filt > accel_lim && !edge_armed && gyro_filt > gyro_lim) begin
            edge_armed = 1'b1;
            if (TIME_W'(now - last_step_ms) >= min_gap_ms) begin
                step_total      = step_total + 1'b1;
                last_step_ms    = now;
                r.step_detected = 1'b1;
            end
        end else if (accel_filt <= accel_lim) begin
            edge_armed = 1'b0;
        end
        r.step_count = step_total;
        return r;
    endfunction

    function automatic void flag_error(string msg);
        o_errors++;
        if (o_errors <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result want;
        if (!i_rst_n) begin
            accel_thr  = ACCEL_THR_RST;
            gyro_thr   = GYRO_THR_RST;
            min_gap_ms = MIN_INT_RST;
            alpha_reg  = ALPHA_RST;
            clear_detector();
            expected_steps.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACCEL_THR: accel_thr  = i_cfg_data;
                    CFG_GYRO_THR:  gyro_thr   = i_cfg_data;
                    CFG_MIN_INT:   min_gap_ms = i_cfg_data;
                    CFG_ALPHA:     alpha_reg  = i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.step_count    = i_m_tdata;
                got.step_detected = i_m_tuser;
                if (expected_steps.size() == 0) begin
                    flag_error($sformatf("unexpected result count=%0d detected=%0b",
                                         got.step_count, got.step_detected));
                end else begin
                    want = expected_steps.pop_front();
                    if (got.step_count !== want.step_count)
                        flag_error($sformatf("step_count exp %0d got %0d",
                                             want.step_count, got.step_count));
                    if (got.step_detected !== want.step_detected)
                        flag_error($sformatf("step_detected exp %0b got %0b",
                                             want.step_detected, got.step_detected));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_steps.push_back(predict_step(i_s_tuser, i_s_tdata));
            o_pending = expected_steps.size();
        end
    end

endmodule

/* test/dual_gate_step_detector_unit_tb.sv */
`timescale 1ns / 1ps

module dual_gate_step_detector_unit_tb;
    import dgsd_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int DATA_W      = ((6*SW+TIME_W+7)/8)*8;
    localparam int LATENCY     = SW + 9;   // spacing from one accept to the next
    localparam int HOLD_CYCLES = 300;      // long result-side stall

    // Indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MID = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI  = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = ACT_PROCESS;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [COUNT_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;

    // Traffic shaping knobs
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int hold_requests = 0;   // bumped by stimulus
    int hold_served   = 0;   // bumped by the result sink

    // Walk generator state
    int                cur_accel_thr;
    int                cur_gyro_thr;
    bit                stride_hi;
    logic [TIME_W-1:0] walk_ms;

    dual_gate_step_detector_unit #(
        .SAMPLE_WIDTH (SW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Scoreboard: mirrors the registers, predicts each result, compares in order
    dgsd_tb_checker #(
        .SW (SW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result sink: random backpressure, plus one long hold-off on request.
    // At most one assignment to tready per falling edge.
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_served + 1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 20);
            end
        end
    end

    // Pack three axes, x in the low bits
    function automatic logic [3*SW-1:0] vec3(int x, int y, int z);
        logic [SW-1:0] vx;
        logic [SW-1:0] vy;
        logic [SW-1:0] vz;
        vx = SW'(x);
        vy = SW'(y);
        vz = SW'(z);
        return {vz, vy, vx};
    endfunction

    // Vector of roughly the given magnitude: one dominant axis, small others,
    // random signs
    function automatic logic [3*SW-1:0] spread(int mag);
        int v[3];
        int k;
        k = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            v[i] = (i == k) ? mag : $urandom_range(0, mag / 8);
            if ($urandom_range(1))
                v[i] = -v[i];
        end
        return vec3(v[0], v[1], v[2]);
    endfunction

    // Magnitude clearly above or below a threshold (in raw units), capped at 32767
    function automatic int pick_level(int thr, bit hi);
        int lvl;
        if (hi)
            lvl = thr + 8 + $urandom_range(thr / 4, thr * 2 + 64);
        else
            lvl = $urandom_range(0, thr * 3 / 4);
        return (lvl > 32767) ? 32767 : lvl;
    endfunction

    // One sample transaction: optional gap, then hold valid until accepted.
    // tvalid is left high so back-to-back items need no extra edge.
    task automatic push_sample(input logic act, input logic [3*SW-1:0] accel,
                               input logic [3*SW-1:0] gyro, input logic [TIME_W-1:0] ms);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(99) < 20)
            gap = $urandom_range(1, 30);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= DATA_W'({ms, gyro, accel});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_profile(input int athr, input int gthr, input int gap_ms,
                               input int alpha);
        write_reg(CFG_ACCEL_THR, CFG_DATA_W'(athr));
        write_reg(CFG_GYRO_THR, CFG_DATA_W'(gthr));
        write_reg(CFG_MIN_INT, CFG_DATA_W'(gap_ms));
        write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
        cur_accel_thr = athr;
        cur_gyro_thr  = gthr;
        walk_ms       = $urandom;
    endtask

    // Mostly walking motion: accel swings across its threshold, gyro gate
    // usually open, time advancing. Some clears and full-range noise mixed in.
    task automatic stride_burst(input int n, input int hold_at);
        int               r;
        logic [3*SW-1:0]  acc;
        logic [3*SW-1:0]  gyr;
        logic [TIME_W-1:0] ms;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at)
                hold_requests = hold_requests + 1;
            r = $urandom_range(99);
            if (r < 3) begin
                push_sample(ACT_CLEAR, (3*SW)'({$urandom, $urandom}),
                            (3*SW)'({$urandom, $urandom}), $urandom);
            end else if (r < 15) begin
                ms = $urandom_range(1) ? walk_ms : $urandom;
                push_sample(ACT_PROCESS, (3*SW)'({$urandom, $urandom}),
                            (3*SW)'({$urandom, $urandom}), ms);
            end else begin
                if ($urandom_range(99) < 35)
                    stride_hi = !stride_hi;
                walk_ms = walk_ms + $urandom_range(5, 300);
                acc = spread(pick_level(cur_accel_thr, stride_hi));
                gyr = spread(pick_level(cur_gyro_thr, $urandom_range(99) < 80));
                push_sample(ACT_PROCESS, acc, gyr, walk_ms);
            end
        end
        drain();
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults, slow filter. A hard first stride arms the edge flag
        // but is too early after power-up to count.
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'd0);
        push_sample(ACT_PROCESS, vec3(-32768, -32768, -32768),
                    vec3(32767, 32767, 32767), 32'd100);
        push_sample(ACT_CLEAR, '1, '1, '1);
        // gyro gate closed: accel above but flag must stay clear
        push_sample(ACT_PROCESS, vec3(-32768, -32768, -32768), vec3(0, 0, 0), 32'd1000);
        push_sample(ACT_PROCESS, vec3(32767, -32768, 32767),
                    vec3(-32768, 32767, -32768), 32'd2000);
        push_sample(ACT_PROCESS, vec3(-1, 1, 0), vec3(0, -32768, 1), 32'hFFFF_FFFF);
        drain();

        // Instant filter (alpha 256) so each sample lands on its threshold
        // directly; exercises interval gating and timestamp wrap.
        set_profile(100, 100, 300, 256);
        push_sample(ACT_CLEAR, '0, '0, '0);
        push_sample(ACT_PROCESS, vec3(200, 0, 0), vec3(0, 200, 0), 32'd1000);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 200, 0), 32'd1100);
        // interval too short: arms but does not count
        push_sample(ACT_PROCESS, vec3(0, -200, 0), vec3(0, 0, -200), 32'd1200);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'd1250);
        push_sample(ACT_PROCESS, vec3(0, 0, 200), vec3(200, 0, 0), 32'd1300);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'd1400);
        push_sample(ACT_PROCESS, vec3(-200, 0, 0), vec3(50, 0, 0), 32'd5000);
        // accel exactly at threshold is not above it
        push_sample(ACT_PROCESS, vec3(100, 0, 0), vec3(200, 0, 0), 32'd5001);
        push_sample(ACT_PROCESS, vec3(0, 101, 0), vec3(0, -101, 0), 32'd5002);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'd5003);
        push_sample(ACT_PROCESS, vec3(300, 0, 0), vec3(300, 0, 0), 32'hFFFF_FF00);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'hFFFF_FF80);
        // across the wrap: 272 ms, then 320 ms since the last step
        push_sample(ACT_PROCESS, vec3(300, 0, 0), vec3(300, 0, 0), 32'h0000_0010);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'h0000_0020);
        push_sample(ACT_PROCESS, vec3(300, 0, 0), vec3(300, 0, 0), 32'h0000_0040);
        drain();

        // Undecoded indexes must leave every register alone
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        push_sample(ACT_PROCESS, vec3(0, 0, 0), vec3(0, 0, 0), 32'h0000_0080);
        drain();

        // Random phases over a spread of settings
        set_profile(2944, 1024, 250, 77);
        stride_burst(100, -1);

        // alpha 0 behaves as 1, all gates wide open
        set_profile(0, 0, 0, 0);
        stride_burst(80, -1);

        // everything at maximum; alpha write carries extra bits above the field
        set_profile(65535, 65535, 65535, 16'hFFFF);
        write_reg(CFG_UNUSED_MID, 16'h0000);
        stride_burst(60, -1);

        // long result-side stall partway through: the block must backpressure
        set_profile(1000, 300, 100, 200);
        stride_burst(100, 30);

        set_profile(4000, 2000, 1000, 256);
        stride_burst(100, -1);

        // full-rate stretch, no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_profile(500, 0, 30, 128);
        stride_burst(100, -1);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Let any stray result show up before the verdict
        repeat (2 * LATENCY) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
